[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_CLK_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CLK_NORST(lbl, clk, prop)
`endif
`endif

[rtl/core/cts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// types and codes shared by the camera trigger scheduler
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOT_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_INTERVAL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH   = 3'd7;

    // auto modes
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ARMED   = 3'd1;
    localparam logic [2:0] MODE_ALWAYS  = 3'd2;
    localparam logic [2:0] MODE_LEVEL   = 3'd3;
    localparam logic [2:0] MODE_MISSION = 3'd4;

    // drive states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHOT  = 2'd1;
    localparam logic [1:0] ST_VIDEO = 2'd2;

    // activity codes
    localparam logic [1:0] ACT_IDLE        = 2'd0;
    localparam logic [1:0] ACT_PICTURE     = 2'd1;
    localparam logic [1:0] ACT_START_VIDEO = 2'd2;
    localparam logic [1:0] ACT_STOP_VIDEO  = 2'd3;

    // trigger reasons
    localparam logic [1:0] REASON_MANUAL   = 2'd0;
    localparam logic [1:0] REASON_TIME     = 2'd1;
    localparam logic [1:0] REASON_DISTANCE = 2'd2;

    // 0.1 in Q2.14
    localparam logic signed [16:0] DEADBAND = 17'sd1638;
    localparam logic [9:0]         MS_TO_US = 10'd1000;

    typedef struct packed {
        logic [31:0]        now_us;
        logic signed [23:0] north_cm;
        logic signed [23:0] east_cm;
        logic signed [15:0] manual_level;
        logic signed [15:0] auto_level;
        logic               armed;
        logic               path_planner;
    } t_in;

    typedef struct packed {
        logic [1:0]  drive;
        logic [1:0]  activity;
        logic        published;
        logic [1:0]  reason;
        logic [15:0] image_count;
    } t_out;

    typedef struct packed {
        logic [2:0]         auto_mode;
        logic               manual_enable;
        logic signed [15:0] shot_level;
        logic signed [15:0] video_level;
        logic [31:0]        min_us;
        logic [31:0]        time_us;
        logic               time_on;
        logic               space_on;
        logic [45:0]        space_sq;
        logic [31:0]        pulse_us;
    } t_cfg;

endpackage

[rtl/core/cts_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_cfg
// configuration registers, intervals kept in microseconds and distance squared
// ----------------------------------------------------------------------------
module cts_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output cts_pkg::t_cfg                 o_cfg
);

    cts_pkg::t_cfg r_cfg;
    logic [31:0]   w_us;
    logic [45:0]   w_sq;

    assign w_us = 32'(i_cfg_data[21:0]) * 32'(cts_pkg::MS_TO_US);
    assign w_sq = 46'(i_cfg_data[22:0]) * 46'(i_cfg_data[22:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cts_pkg::CFG_AUTO_MODE:     r_cfg.auto_mode     <= i_cfg_data[2:0];
                cts_pkg::CFG_MANUAL_ENABLE: r_cfg.manual_enable <= i_cfg_data[0];
                cts_pkg::CFG_SHOT_LEVEL:    r_cfg.shot_level    <= i_cfg_data[15:0];
                cts_pkg::CFG_VIDEO_LEVEL:   r_cfg.video_level   <= i_cfg_data[15:0];
                cts_pkg::CFG_MIN_INTERVAL:  r_cfg.min_us        <= w_us;
                cts_pkg::CFG_TIME_INTERVAL: begin
                    r_cfg.time_us <= w_us;
                    r_cfg.time_on <= (i_cfg_data[21:0] != 22'd0);
                end
                cts_pkg::CFG_SPACE_INTERVAL: begin
                    r_cfg.space_sq <= w_sq;
                    r_cfg.space_on <= (i_cfg_data[22:0] != 23'd0);
                end
                cts_pkg::CFG_PULSE_WIDTH:   r_cfg.pulse_us      <= w_us;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/cts_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_core
// trigger decision for one tick and the scheduler state it updates
// ----------------------------------------------------------------------------
module cts_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  cts_pkg::t_cfg i_cfg,
    input  cts_pkg::t_in  i_item,
    output cts_pkg::t_out o_res
);

    logic [31:0]        r_last_time;
    logic signed [23:0] r_last_north;
    logic signed [23:0] r_last_east;
    logic [1:0]         r_shown;
    logic [1:0]         r_manual;
    logic [15:0]        r_count;
    logic [1:0]         r_reason;
    logic [1:0]         r_activity;

    logic [1:0]         n_shown;
    logic [1:0]         n_manual;
    logic [15:0]        n_count;
    logic [1:0]         n_reason;
    logic [1:0]         n_activity;

    logic signed [16:0] w_d_shot;
    logic signed [16:0] w_d_video;
    logic               w_auto_en;
    logic [31:0]        w_since;
    logic signed [24:0] w_dn;
    logic signed [24:0] w_de;
    logic signed [49:0] w_sq_n;
    logic signed [49:0] w_sq_e;
    logic [49:0]        w_d2;
    logic               w_trig_manual;
    logic               w_auto_due;
    logic               w_time_hit;
    logic               w_dist_hit;
    logic               w_trigger;
    logic [1:0]         w_wanted;
    logic               w_published;

    // manual level classification
    assign w_d_shot  = $signed({i_item.manual_level[15], i_item.manual_level})
                     - $signed({i_cfg.shot_level[15], i_cfg.shot_level});
    assign w_d_video = $signed({i_item.manual_level[15], i_item.manual_level})
                     - $signed({i_cfg.video_level[15], i_cfg.video_level});

    always_comb begin
        n_manual = r_manual;
        if (i_cfg.manual_enable) begin
            if (w_d_shot >= -cts_pkg::DEADBAND && w_d_shot <= cts_pkg::DEADBAND) begin
                n_manual = cts_pkg::ST_SHOT;
            end else if (w_d_video >= -cts_pkg::DEADBAND
                         && w_d_video <= cts_pkg::DEADBAND) begin
                n_manual = cts_pkg::ST_VIDEO;
            end else begin
                n_manual = cts_pkg::ST_IDLE;
            end
        end
    end

    always_comb begin
        unique case (i_cfg.auto_mode)
            cts_pkg::MODE_ARMED:   w_auto_en = i_item.armed;
            cts_pkg::MODE_ALWAYS:  w_auto_en = 1'b1;
            cts_pkg::MODE_LEVEL:   w_auto_en =
                $signed({i_item.auto_level[15], i_item.auto_level}) > cts_pkg::DEADBAND;
            cts_pkg::MODE_MISSION: w_auto_en = i_item.path_planner;
            default:               w_auto_en = 1'b0;
        endcase
    end

    // time and distance squared since the last trigger
    assign w_since = i_item.now_us - r_last_time;
    assign w_dn    = $signed({i_item.north_cm[23], i_item.north_cm})
                   - $signed({r_last_north[23], r_last_north});
    assign w_de    = $signed({i_item.east_cm[23], i_item.east_cm})
                   - $signed({r_last_east[23], r_last_east});
    assign w_sq_n  = w_dn * w_dn;
    assign w_sq_e  = w_de * w_de;
    assign w_d2    = $unsigned(w_sq_n) + $unsigned(w_sq_e);

    // manual trigger when the new manual class differs from the stored one and is not idle
    assign w_trig_manual = (n_manual != r_manual) && (n_manual != cts_pkg::ST_IDLE);
    assign w_auto_due    = !w_trig_manual && w_auto_en && (w_since > i_cfg.min_us);
    assign w_time_hit    = w_auto_due && i_cfg.time_on && (w_since > i_cfg.time_us);
    assign w_dist_hit    = w_auto_due && i_cfg.space_on && (w_d2 > {4'd0, i_cfg.space_sq});
    assign w_trigger     = w_trig_manual || w_time_hit || w_dist_hit;

    always_comb begin
        n_reason = r_reason;
        w_wanted = cts_pkg::ST_IDLE;
        if (w_trig_manual) begin
            n_reason = cts_pkg::REASON_MANUAL;
            w_wanted = n_manual;
        end else if (w_dist_hit) begin
            n_reason = cts_pkg::REASON_DISTANCE;
            w_wanted = cts_pkg::ST_SHOT;
        end else if (w_time_hit) begin
            n_reason = cts_pkg::REASON_TIME;
            w_wanted = cts_pkg::ST_SHOT;
        end
    end

    assign n_count = w_trigger ? r_count + 16'd1 : r_count;

    always_comb begin
        n_activity  = w_trigger ? r_activity : cts_pkg::ACT_IDLE;
        w_published = 1'b0;
        n_shown     = w_wanted;
        if (w_wanted != r_shown) begin
            if (w_wanted == cts_pkg::ST_IDLE) begin
                n_activity = (r_shown == cts_pkg::ST_VIDEO) ? cts_pkg::ACT_STOP_VIDEO
                                                            : cts_pkg::ACT_IDLE;
            end else if (w_wanted == cts_pkg::ST_SHOT) begin
                n_activity = cts_pkg::ACT_PICTURE;
            end else begin
                n_activity = cts_pkg::ACT_START_VIDEO;
            end
            w_published = (n_activity != cts_pkg::ACT_IDLE) || (r_shown != cts_pkg::ST_SHOT);
            // shot drive held for the pulse width
            if (w_wanted == cts_pkg::ST_IDLE && r_shown == cts_pkg::ST_SHOT) begin
                n_shown = (w_since > i_cfg.pulse_us) ? cts_pkg::ST_IDLE : cts_pkg::ST_SHOT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_last_north <= '0;
            r_last_east  <= '0;
            r_shown      <= cts_pkg::ST_IDLE;
            r_manual     <= cts_pkg::ST_IDLE;
            r_count      <= '0;
            r_reason     <= cts_pkg::REASON_MANUAL;
            r_activity   <= cts_pkg::ACT_IDLE;
        end else if (i_adv) begin
            if (w_trigger) begin
                r_last_time  <= i_item.now_us;
                r_last_north <= i_item.north_cm;
                r_last_east  <= i_item.east_cm;
            end
            r_shown    <= n_shown;
            r_manual   <= n_manual;
            r_count    <= n_count;
            r_reason   <= n_reason;
            r_activity <= n_activity;
        end
    end

    assign o_res.drive       = n_shown;
    assign o_res.activity    = n_activity;
    assign o_res.published   = w_published;
    assign o_res.reason      = n_reason;
    assign o_res.image_count = n_count;

endmodule

[rtl/core/camera_trigger_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_trigger_scheduler_top
// camera trigger scheduler with input register, decision core and result register
// ----------------------------------------------------------------------------
// One tick is taken per clock while the output is not stalled, and gives one
// result: the tick waits in the input register, the decision and all state
// updates happen as it moves on to the output register, and the result sits in
// the output register until it is taken. Throughput is set by the loop
// through the trigger state (last trigger time and position), so a stalled
// output stops the input only once both registers are full. Configuration
// writes take effect in the cycle after the write.
module camera_trigger_scheduler_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  cts_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output cts_pkg::t_out                  o_data
);

    `include "assert_macros.svh"

    cts_pkg::t_cfg w_cfg;
    cts_pkg::t_in  r_in;
    logic          r_in_vld;
    cts_pkg::t_out r_out;
    logic          r_out_vld;
    cts_pkg::t_out w_res;
    logic          w_adv;

    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;

    cts_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (w_cfg),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // a held tick blocks new transfers
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, (r_in_vld && !w_adv) |-> !o_ready)
    // a waiting result is never overwritten
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (r_out_vld && !i_ready) |-> !w_adv)
    // video drive only comes from the manual channel
    `ASSERT_CLK(a_video_manual, i_clk, i_rst_n,
        (w_adv && w_res.drive == cts_pkg::ST_VIDEO) |-> w_res.reason == cts_pkg::REASON_MANUAL)
    // a published shot is always a picture
    `ASSERT_CLK(a_shot_picture, i_clk, i_rst_n,
        (w_adv && w_res.published && w_res.drive == cts_pkg::ST_SHOT)
        |-> w_res.activity == cts_pkg::ACT_PICTURE)

endmodule
